// ===== rtl/core/ordered_value_list_assert.svh =====
// ----------------------------------------------------------------------------
// ordered_value_list assertion macros
// shared property forms for the ordered value list checks
// ----------------------------------------------------------------------------
`ifndef ORDERED_VALUE_LIST_ASSERT_SVH
`define ORDERED_VALUE_LIST_ASSERT_SVH

// antecedent holds -> consequent holds in the same cycle
`define OVL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// antecedent holds -> consequent holds in the next cycle
`define OVL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/ovl_pkg.sv =====
// ----------------------------------------------------------------------------
// ovl_pkg
// types and constants shared by the ordered value list modules
// ----------------------------------------------------------------------------
package ovl_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int VALUE_W      = 32;
    localparam int LENGTH_W     = 5;

    typedef enum logic [1:0] {
        MODE_FRONT  = 2'd0,
        MODE_BACK   = 2'd1,
        MODE_DELETE = 2'd2,
        MODE_SEARCH = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_FULL    = 2'd1,
        ST_MISSING = 2'd2
    } t_status;

    typedef struct packed {
        t_mode                     mode;
        logic signed [VALUE_W-1:0] value;
    } t_in;

    typedef struct packed {
        t_status             status;
        logic                found;
        logic [LENGTH_W-1:0] length;
    } t_out;

    // command broadcast to every cell
    typedef struct packed {
        logic               fire;
        logic               full;
        t_mode              mode;
        logic [VALUE_W-1:0] value;
    } t_cell_ctl;

    // contents handed between neighboring cells
    typedef struct packed {
        logic               occ;
        logic [VALUE_W-1:0] data;
    } t_link;

endpackage

// ===== rtl/core/ordered_value_list.sv =====
// ----------------------------------------------------------------------------
// ordered_value_list
// ordered list of signed 32-bit values with insert, delete and search
// ----------------------------------------------------------------------------
// Each command is held in an input register and carried out by a row of
// CAPACITY cells, which compare against the value in parallel, find the first
// match through a ripple down the row and shift left or right in place.
// A command then lands in an output register, so one command per cycle is
// taken when the result side keeps up; the input register lets one more
// command in while a result waits. A result passes the input register and
// then the output register. The length of the compare ripple through the
// cells sets the clock. Reset empties the list at once.
`include "ordered_value_list_assert.svh"

module ordered_value_list
    import ovl_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic             r_cmd_v;
    t_in              r_cmd;
    logic             r_out_v;
    t_out             r_out;
    logic [CNT_W-1:0] r_count;

    logic             n_cmd_v;
    logic             n_out_v;
    t_out             n_out;
    logic [CNT_W-1:0] n_count;

    logic      w_fire;
    logic      w_full;
    logic      w_found;
    t_cell_ctl w_ctl;
    t_status   w_status;

    assign w_fire      = r_cmd_v && (!r_out_v || !i_out_stall);
    assign w_full      = (r_count == CNT_W'(CAPACITY));
    assign o_in_stall  = r_cmd_v && !w_fire;
    assign o_out_valid = r_out_v;
    assign o_out       = r_out;

    assign w_ctl = '{fire: w_fire, full: w_full, mode: r_cmd.mode,
                     value: r_cmd.value};

    ovl_chain #(
        .CAPACITY (CAPACITY)
    ) u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .o_found (w_found)
    );

    always_comb begin
        n_count  = r_count;
        w_status = ST_DONE;
        unique case (r_cmd.mode)
            MODE_FRONT, MODE_BACK: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            MODE_DELETE: begin
                if (w_found) begin
                    n_count = r_count - CNT_W'(1);
                end else begin
                    w_status = ST_MISSING;
                end
            end
            default: begin
                if (!w_found) begin
                    w_status = ST_MISSING;
                end
            end
        endcase

        n_out   = '{status: w_status, found: w_found, length: LENGTH_W'(n_count)};
        n_cmd_v = r_cmd_v;
        if (w_fire) begin
            n_cmd_v = 1'b0;
        end
        if (i_in_valid && !o_in_stall) begin
            n_cmd_v = 1'b1;
        end
        n_out_v = r_out_v && i_out_stall;
        if (w_fire) begin
            n_out_v = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_v <= 1'b0;
            r_out_v <= 1'b0;
            r_count <= '0;
        end else begin
            r_cmd_v <= n_cmd_v;
            r_out_v <= n_out_v;
            if (w_fire) begin
                r_count <= n_count;
            end
        end
        if (i_in_valid && !o_in_stall) begin
            r_cmd <= i_in;
        end
        if (w_fire) begin
            r_out <= n_out;
        end
    end

    `OVL_ASSERT_NOW(a_count_max, 1'b1, r_count <= CNT_W'(CAPACITY), "count above capacity")
    `OVL_ASSERT_NEXT(a_full_keeps, w_fire && w_full && (r_cmd.mode == MODE_FRONT || r_cmd.mode == MODE_BACK), $stable(r_count), "refused insert changed count")
    `OVL_ASSERT_NEXT(a_delete_dec, w_fire && w_found && r_cmd.mode == MODE_DELETE, r_count == $past(r_count) - CNT_W'(1), "delete hit did not shrink list")
    `OVL_ASSERT_NOW(a_search_keeps, w_fire && r_cmd.mode == MODE_SEARCH, n_count == r_count, "search changed count")

endmodule

// ===== rtl/core/ovl_cell.sv =====
// ----------------------------------------------------------------------------
// ovl_cell
// one list slot: holds an entry, compares it and shifts to either neighbor
// ----------------------------------------------------------------------------
module ovl_cell
    import ovl_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_link     i_left,
    input  t_link     i_right,
    input  logic      i_hit,
    output t_link     o_link,
    output logic      o_hit
);

    logic               r_occ;
    logic [VALUE_W-1:0] r_data;
    logic               n_occ;
    logic [VALUE_W-1:0] n_data;
    logic               w_match;

    assign w_match = r_occ && (r_data == i_ctl.value);
    assign o_hit   = i_hit | w_match;
    assign o_link  = '{occ: r_occ, data: r_data};

    always_comb begin
        n_occ  = r_occ;
        n_data = r_data;
        if (i_ctl.fire) begin
            unique case (i_ctl.mode)
                MODE_FRONT: begin
                    if (!i_ctl.full) begin
                        n_occ  = i_left.occ;
                        n_data = i_left.data;
                    end
                end
                MODE_BACK: begin
                    // first empty slot takes the value
                    if (!i_ctl.full && !r_occ && i_left.occ) begin
                        n_occ  = 1'b1;
                        n_data = i_ctl.value;
                    end
                end
                MODE_DELETE: begin
                    // slots at or after the first match pull from the right
                    if (o_hit) begin
                        n_occ  = i_right.occ;
                        n_data = i_right.data;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else begin
            r_occ <= n_occ;
        end
        r_data <= n_data;
    end

endmodule

// ===== rtl/core/ovl_chain.sv =====
// ----------------------------------------------------------------------------
// ovl_chain
// row of list cells, head at cell 0, with the match ripple running down it
// ----------------------------------------------------------------------------
module ovl_chain
    import ovl_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    output logic      o_found
);

    t_link w_link [CAPACITY];
    logic  w_hit  [CAPACITY+1];

    assign w_hit[0] = 1'b0;
    assign o_found  = w_hit[CAPACITY];

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_link w_left;
        t_link w_right;

        if (g == 0) begin : g_head
            // head sees an occupied slot carrying the new value
            assign w_left = '{occ: 1'b1, data: i_ctl.value};
        end else begin : g_mid_l
            assign w_left = w_link[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_right = '{occ: 1'b0, data: '0};
        end else begin : g_mid_r
            assign w_right = w_link[g+1];
        end

        ovl_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (i_ctl),
            .i_left  (w_left),
            .i_right (w_right),
            .i_hit   (w_hit[g]),
            .o_link  (w_link[g]),
            .o_hit   (w_hit[g+1])
        );
    end

endmodule

// ===== tb/ordered_value_list_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_value_list_tb
// drives list commands through the valid/stall ports and checks every result
// against table values or a queue-based mirror of the list kept inside the bench
// ----------------------------------------------------------------------------
// A short table of commands covers the empty list, value extremes, duplicates
// and inserts into a full list. Random commands follow in alternating fill and
// drain phases, with deletes and searches mostly aimed at values held in the
// list. Both sides idle at random. Once, the result side holds off for a long
// stretch while commands keep coming, and twice the command side waits for
// every outstanding result.
module ordered_value_list_tb;
    import ovl_pkg::*;

    localparam int LIST_DEPTH     = CAPACITY_DEF;
    localparam int RESET_CYCLES   = 8;
    localparam int RANDOM_ITEMS   = 830;
    localparam int LONG_HOLD      = 150;
    localparam int BURST_ITEMS    = 40;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        t_mode       mode;
        logic [31:0] value;
        logic [4:0]  reps;
        logic        typed;
        t_out        want;
    } t_row;

    localparam int N_ROWS = 15;
    localparam t_row DIRECTED [N_ROWS] = '{
        '{MODE_SEARCH, 32'h0000_0000, 5'd1,  1'b1, '{ST_MISSING, 1'b0, 5'd0}},
        '{MODE_DELETE, 32'h0000_0005, 5'd1,  1'b1, '{ST_MISSING, 1'b0, 5'd0}},
        '{MODE_FRONT,  32'h8000_0000, 5'd1,  1'b1, '{ST_DONE,    1'b0, 5'd1}},
        '{MODE_BACK,   32'h7fff_ffff, 5'd1,  1'b1, '{ST_DONE,    1'b0, 5'd2}},
        '{MODE_FRONT,  32'h0000_0000, 5'd1,  1'b1, '{ST_DONE,    1'b0, 5'd3}},
        '{MODE_BACK,   32'hffff_ffff, 5'd1,  1'b1, '{ST_DONE,    1'b0, 5'd4}},
        '{MODE_SEARCH, 32'h8000_0000, 5'd1,  1'b1, '{ST_DONE,    1'b1, 5'd4}},
        // duplicate goes to the head, delete must take that one first
        '{MODE_FRONT,  32'h7fff_ffff, 5'd1,  1'b1, '{ST_DONE,    1'b1, 5'd5}},
        '{MODE_DELETE, 32'h7fff_ffff, 5'd1,  1'b1, '{ST_DONE,    1'b1, 5'd4}},
        '{MODE_SEARCH, 32'h7fff_ffff, 5'd1,  1'b0, '0},
        // fill to capacity with one repeated value
        '{MODE_BACK,   32'h5555_aaaa, 5'd12, 1'b0, '0},
        '{MODE_FRONT,  32'h0000_0001, 5'd1,  1'b1, '{ST_FULL,    1'b0, 5'd16}},
        '{MODE_BACK,   32'h8000_0000, 5'd1,  1'b1, '{ST_FULL,    1'b1, 5'd16}},
        '{MODE_DELETE, 32'h5555_aaaa, 5'd1,  1'b1, '{ST_DONE,    1'b1, 5'd15}},
        '{MODE_DELETE, 32'h0001_2345, 5'd1,  1'b1, '{ST_MISSING, 1'b0, 5'd15}}
    };

    localparam logic [31:0] VALUE_POOL [6] = '{
        32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000,
        32'hffff_ffff, 32'h0000_0001, 32'h0000_ffff
    };

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic o_in_stall;
    t_in  i_in        = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_out o_out;

    logic [31:0] list_mirror [$];
    t_out        pending_results [$];
    int          errors      = 0;
    int          idle_cycles = 0;
    bit          hold_req    = 1'b0;
    bit          send_idle   = 1'b1;
    int          burst_left  = 0;

    ordered_value_list #(
        .CAPACITY (LIST_DEPTH)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    always #5 i_clk = ~i_clk;

    // applies one command to the mirror and returns the result it gives
    function automatic t_out list_result(input t_in cmd);
        t_out r;
        int   pos;
        pos = -1;
        foreach (list_mirror[i]) begin
            if (pos < 0 && list_mirror[i] == cmd.value) pos = i;
        end
        r.found  = (pos >= 0);
        r.status = ST_DONE;
        case (cmd.mode)
            MODE_FRONT, MODE_BACK: begin
                if (list_mirror.size() >= LIST_DEPTH) begin
                    r.status = ST_FULL;
                end else if (cmd.mode == MODE_FRONT) begin
                    list_mirror.push_front(cmd.value);
                end else begin
                    list_mirror.push_back(cmd.value);
                end
            end
            MODE_DELETE: begin
                if (pos >= 0) list_mirror.delete(pos);
                else r.status = ST_MISSING;
            end
            default: begin
                if (pos < 0) r.status = ST_MISSING;
            end
        endcase
        r.length = LENGTH_W'(list_mirror.size());
        return r;
    endfunction

    // offers one command, holds it until the transfer, then records the result
    task automatic send_cmd(input t_in cmd, input bit typed, input t_out want);
        int   gap;
        t_out predicted;
        if ($urandom_range(0, 39) == 0) send_idle = !send_idle;
        if (burst_left > 0) begin
            gap = 0;
            burst_left--;
        end else begin
            gap = send_idle ? $urandom_range(0, 18) : 0;
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= cmd;
        do @(posedge i_clk); while (o_in_stall);
        predicted = list_result(cmd);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_result(input t_out got);
        t_out want;
        if (pending_results.size() == 0) begin
            $display("%0t: unexpected result status %0d found %0d length %0d",
                     $time, got.status, got.found, got.length);
            errors++;
        end else begin
            want = pending_results.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status mismatch, expected %0d, actual %0d",
                         $time, want.status, got.status);
                errors++;
            end
            if (got.found !== want.found) begin
                $display("%0t: found mismatch, expected %0d, actual %0d",
                         $time, want.found, got.found);
                errors++;
            end
            if (got.length !== want.length) begin
                $display("%0t: length mismatch, expected %0d, actual %0d",
                         $time, want.length, got.length);
                errors++;
            end
        end
    endtask

    initial begin : stimulus
        t_in  cmd;
        t_mode mode;
        bit   fill_phase;
        int   pick;
        fill_phase = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED[r]) begin
            for (int k = 0; k < DIRECTED[r].reps; k++) begin
                cmd.mode  = DIRECTED[r].mode;
                cmd.value = DIRECTED[r].value;
                send_cmd(cmd, DIRECTED[r].typed, DIRECTED[r].want);
            end
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 60 == 0) fill_phase = !fill_phase;
            // result side stops for a long stretch while commands keep coming
            if (n == 200) begin
                hold_req   = 1'b1;
                burst_left = BURST_ITEMS;
            end
            if (n == 450 || n == 700) wait_results_drained();

            pick = $urandom_range(0, 99);
            if (fill_phase) begin
                if (pick < 30)      mode = MODE_FRONT;
                else if (pick < 60) mode = MODE_BACK;
                else if (pick < 80) mode = MODE_DELETE;
                else                mode = MODE_SEARCH;
            end else begin
                if (pick < 10)      mode = MODE_FRONT;
                else if (pick < 20) mode = MODE_BACK;
                else if (pick < 75) mode = MODE_DELETE;
                else                mode = MODE_SEARCH;
            end
            cmd.mode = mode;
            // deletes and searches mostly aim at something held in the list
            if ((mode == MODE_DELETE || mode == MODE_SEARCH) && list_mirror.size() != 0
                    && $urandom_range(0, 9) < 7) begin
                cmd.value = list_mirror[$urandom_range(0, list_mirror.size() - 1)];
            end else if ($urandom_range(0, 1) == 1) begin
                cmd.value = VALUE_POOL[$urandom_range(0, 5)];
            end else begin
                cmd.value = $urandom;
            end
            send_cmd(cmd, 1'b0, '0);
        end

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("ordered_value_list_tb OK");
        end else begin
            $display("ordered_value_list_tb NOT OK");
        end
        $finish;
    end

    initial begin : result_side
        int stall_left;
        bit recv_idle;
        stall_left = 0;
        recv_idle  = 1'b1;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall) begin
                check_result(o_out);
                if ($urandom_range(0, 39) == 0) recv_idle = !recv_idle;
                stall_left = recv_idle ? $urandom_range(0, 18) : 0;
            end else if (stall_left > 0) begin
                stall_left--;
            end
            if (hold_req) begin
                stall_left = LONG_HOLD;
                hold_req   = 1'b0;
            end
            i_out_stall <= (stall_left != 0);
        end
    end

    // cycles with no transfer on either side
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("ordered_value_list_tb NOT OK");
            $finish;
        end
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/ovl_pkg.sv
rtl/core/ovl_cell.sv
rtl/core/ovl_chain.sv
rtl/core/ordered_value_list.sv
tb/ordered_value_list_tb.sv
